// ===== rtl/mfd_pkg.sv =====
// mfd_pkg: types, constants and helper functions of the motor feedback frame decoder
// no dependencies; compile first
package mfd_pkg;

  localparam int FRAME_W   = 64;
  localparam int LEN_W     = 4;
  localparam int CFG_W     = 32;
  localparam int CFG_IDX_W = 3;
  localparam int VAL_W     = 32;
  localparam int TURN_W    = 32;
  localparam int ANGLE_W   = 48;
  localparam int BYTE_W    = 8;
  localparam int ID_W      = 4;
  localparam int FAULT_W   = 3;

  // defaults of the top level parameters
  localparam int POSITION_BITS_DEF    = 16;
  localparam int SMALL_FIELD_BITS_DEF = 12;
  localparam int QUEUE_DEPTH_DEF      = 4;

  // widest codes the frame can carry
  localparam int POS_CODE_MAX   = 16;
  localparam int SMALL_CODE_MAX = 12;

  // frame layout, byte 0 in the top bits
  localparam int ERR_MSB   = 63;
  localparam int ID_MSB    = 59;
  localparam int POS_MSB   = 55;
  localparam int VEL_MSB   = 39;
  localparam int TORQ_MSB  = 27;
  localparam int MOS_MSB   = 15;
  localparam int ROTOR_MSB = 7;

  localparam logic [LEN_W-1:0] FRAME_BYTES = LEN_W'(8);

  // raw error nibbles that are reported
  localparam logic [ID_W-1:0] FAULT_LO   = 4'h8;
  localparam logic [ID_W-1:0] FAULT_HI   = 4'hE;
  localparam logic [ID_W-1:0] FAULT_BIAS = 4'h7;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_POS_MIN  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_POS_MAX  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_MIN  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_VEL_MAX  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TORQ_MIN = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TORQ_MAX = 3'd5;

  localparam logic signed [CFG_W-1:0] POS_MIN_RST  = -32'sd819200;
  localparam logic signed [CFG_W-1:0] POS_MAX_RST  = 32'sd819200;
  localparam logic signed [CFG_W-1:0] VEL_MIN_RST  = -32'sd1966080;
  localparam logic signed [CFG_W-1:0] VEL_MAX_RST  = 32'sd1966080;
  localparam logic signed [CFG_W-1:0] TORQ_MIN_RST = -32'sd655360;
  localparam logic signed [CFG_W-1:0] TORQ_MAX_RST = 32'sd655360;

  typedef struct packed {
    logic signed [CFG_W-1:0] pos_min;
    logic signed [CFG_W-1:0] pos_max;
    logic signed [CFG_W-1:0] vel_min;
    logic signed [CFG_W-1:0] vel_max;
    logic signed [CFG_W-1:0] torq_min;
    logic signed [CFG_W-1:0] torq_max;
  } cfg_t;

  // one classified frame, codes right aligned
  typedef struct packed {
    logic                      ok;
    logic [ID_W-1:0]           motor_id;
    logic [FAULT_W-1:0]        fault;
    logic [POS_CODE_MAX-1:0]   pcode;
    logic [SMALL_CODE_MAX-1:0] vcode;
    logic [SMALL_CODE_MAX-1:0] tcode;
    logic [BYTE_W-1:0]         mos_temp;
    logic [BYTE_W-1:0]         rotor_temp;
  } frame_item_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // fold steps needed to divide an xw-bit value by 2^n - 1
  function automatic int fold_steps(input int xw, input int n);
    int w;
    int cnt;
    w = xw;
    cnt = 0;
    for (int i = 0; i < 64; i++) begin
      if (w > n + 1) begin
        w = ((w - n > n) ? w - n : n) + 1;
        cnt++;
      end
    end
    return cnt + 2;
  endfunction

  function automatic int max_int(input int a, input int b);
    return (a > b) ? a : b;
  endfunction

endpackage

// ===== rtl/mfd_if.sv =====
// mfd_in_if / mfd_out_if: valid-ready channels of the frame decoder
// depends on mfd_pkg
interface mfd_in_if import mfd_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [FRAME_W-1:0]   frame_data;
  logic [LEN_W-1:0]     frame_length;

  modport source(output valid, frame_data, frame_length, input ready);
  modport sink(input valid, frame_data, frame_length, output ready);
endinterface

interface mfd_out_if import mfd_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic                       accepted;
  logic [ID_W-1:0]            motor_id;
  logic [FAULT_W-1:0]         fault_code;
  logic signed [VAL_W-1:0]    position;
  logic signed [VAL_W-1:0]    velocity;
  logic signed [VAL_W-1:0]    torque;
  logic [BYTE_W-1:0]          mos_temp;
  logic [BYTE_W-1:0]          rotor_temp;
  logic signed [TURN_W-1:0]   turn_total;
  logic signed [ANGLE_W-1:0]  angle_total;

  modport source(output valid, accepted, motor_id, fault_code, position, velocity, torque,
                 mos_temp, rotor_temp, turn_total, angle_total, input ready);
  modport sink(input valid, accepted, motor_id, fault_code, position, velocity, torque,
               mos_temp, rotor_temp, turn_total, angle_total, output ready);
endinterface

// ===== rtl/mfd_front.sv =====
// mfd_front: input register that takes a frame, checks its length and unpacks its fields
// depends on mfd_pkg and mfd_in_if
module mfd_front import mfd_pkg::*; #(
  parameter int POSITION_BITS    = POSITION_BITS_DEF,
  parameter int SMALL_FIELD_BITS = SMALL_FIELD_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  mfd_in_if.sink      in_if,
  input  q_stat_t     q_stat,
  output logic        push,
  output frame_item_t item
);

  logic        f_valid_r;
  frame_item_t f_item_r;
  frame_item_t cls;
  logic        take;
  logic [ID_W-1:0] err;

  assign push        = f_valid_r && !q_stat.full;
  assign in_if.ready = !f_valid_r || !q_stat.full;
  assign take        = in_if.valid && in_if.ready;
  assign item        = f_item_r;
  assign err         = in_if.frame_data[ERR_MSB -: ID_W];

  always_comb begin
    cls.ok         = in_if.frame_length >= FRAME_BYTES;
    cls.motor_id   = in_if.frame_data[ID_MSB -: ID_W];
    cls.fault      = (err >= FAULT_LO && err <= FAULT_HI) ? FAULT_W'(err - FAULT_BIAS) : '0;
    cls.pcode      = POS_CODE_MAX'(in_if.frame_data[POS_MSB -: POSITION_BITS]);
    cls.vcode      = SMALL_CODE_MAX'(in_if.frame_data[VEL_MSB -: SMALL_FIELD_BITS]);
    cls.tcode      = SMALL_CODE_MAX'(in_if.frame_data[TORQ_MSB -: SMALL_FIELD_BITS]);
    cls.mos_temp   = in_if.frame_data[MOS_MSB -: BYTE_W];
    cls.rotor_temp = in_if.frame_data[ROTOR_MSB -: BYTE_W];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      f_valid_r <= 1'b0;
    end else if (take) begin
      f_valid_r <= 1'b1;
    end else if (push) begin
      f_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      f_item_r <= cls;
    end
  end

endmodule

// ===== rtl/mfd_fifo.sv =====
// mfd_fifo: short first-in first-out queue in flip-flops between front and back
// depends on mfd_pkg
module mfd_fifo import mfd_pkg::*; #(
  parameter int WIDTH = $bits(frame_item_t),
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] din,
  input  logic             pop,
  output logic [WIDTH-1:0] dout,
  output q_stat_t          stat
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  assign stat.full  = cnt_r == CNT_W'(DEPTH);
  assign stat.empty = cnt_r == '0;
  assign dout       = mem_r[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CNT_W'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== rtl/mfd_map.sv =====
// mfd_map: pipelined linear map of a code onto [lo, hi], rounded, saturated to 32 bits
// depends on mfd_pkg; the code, each fold step and the value are registered on adv
module mfd_map import mfd_pkg::*; #(
  parameter int CODE_BITS = SMALL_FIELD_BITS_DEF,
  parameter int FOLDS     = fold_steps(SMALL_FIELD_BITS_DEF + CFG_W, SMALL_FIELD_BITS_DEF)
) (
  input  logic                    clk,
  input  logic                    adv,
  input  logic [CODE_BITS-1:0]    code,
  input  logic signed [CFG_W-1:0] lo,
  input  logic signed [CFG_W-1:0] hi,
  output logic signed [VAL_W-1:0] value
);

  localparam int XW = CODE_BITS + CFG_W;
  localparam int QW = CFG_W;
  localparam int VW = CFG_W + 3;
  localparam logic [XW-1:0] DEN  = {{(XW - CODE_BITS){1'b0}}, {CODE_BITS{1'b1}}};
  localparam logic [XW-1:0] HALF = DEN >> 1;
  localparam logic signed [VW-1:0] V_HI = 35'sd2147483647;
  localparam logic signed [VW-1:0] V_LO = -35'sd2147483648;

  logic signed [CFG_W:0]   span;
  logic [CFG_W:0]          span_abs;
  logic [CFG_W-1:0]        mag_r;
  logic                    neg_r;
  logic signed [CFG_W-1:0] lo_r;
  logic [XW-1:0]           prod;

  logic [XW-1:0] r_r [FOLDS+1];
  logic [QW-1:0] q_r [FOLDS+1];

  logic                    carry;
  logic signed [VW-1:0]    lo_x, q_x, c_x, v_sum;
  logic signed [VAL_W-1:0] v_sat;
  logic signed [VAL_W-1:0] val_r;

  // span magnitude, sign; the user ensures config only changes while idle, unchecked
  assign span     = (CFG_W + 1)'(hi) - (CFG_W + 1)'(lo);
  assign span_abs = span[CFG_W] ? (CFG_W + 1)'(-span) : (CFG_W + 1)'(span);

  always_ff @(posedge clk) begin
    mag_r <= span_abs[CFG_W-1:0];
    neg_r <= span[CFG_W];
    lo_r  <= lo;
  end

  assign prod = XW'(code) * XW'(mag_r);

  always_ff @(posedge clk) begin
    if (adv) begin
      r_r[0] <= prod + HALF;
      q_r[0] <= '0;
    end
  end

  // divide by 2^n - 1: x = a*2^n + b gives x/den = a + (a + b)/den
  for (genvar k = 0; k < FOLDS; k++) begin : g_fold
    always_ff @(posedge clk) begin
      if (adv) begin
        r_r[k+1] <= (r_r[k] >> CODE_BITS) + (r_r[k] & DEN);
        q_r[k+1] <= q_r[k] + QW'(r_r[k] >> CODE_BITS);
      end
    end
  end

  assign carry = r_r[FOLDS] >= DEN;

  always_comb begin
    lo_x  = VW'(lo_r);
    q_x   = $signed({3'b000, q_r[FOLDS]});
    c_x   = $signed({{(VW - 1){1'b0}}, carry});
    v_sum = neg_r ? (lo_x - q_x - c_x) : (lo_x + q_x + c_x);
    if (v_sum > V_HI) begin
      v_sat = V_HI[VAL_W-1:0];
    end else if (v_sum < V_LO) begin
      v_sat = V_LO[VAL_W-1:0];
    end else begin
      v_sat = v_sum[VAL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      val_r <= v_sat;
    end
  end

  assign value = val_r;

endmodule

// ===== rtl/mfd_back.sv =====
// mfd_back: mapping lanes, position unwrap, multi-turn state and result register
// depends on mfd_pkg, mfd_out_if and mfd_map
module mfd_back import mfd_pkg::*; #(
  parameter int POSITION_BITS    = POSITION_BITS_DEF,
  parameter int SMALL_FIELD_BITS = SMALL_FIELD_BITS_DEF,
  parameter int FOLDS            = fold_steps(SMALL_FIELD_BITS_DEF + CFG_W,
                                              SMALL_FIELD_BITS_DEF)
) (
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  frame_item_t head,
  input  q_stat_t     q_stat,
  output logic        pop,
  mfd_out_if.source   out_if
);

  localparam int LAT = FOLDS + 2;
  localparam int DW  = CFG_W + 2;
  localparam logic signed [TURN_W-1:0] TURN_HI = 32'sh7FFF_FFFF;
  localparam logic signed [TURN_W-1:0] TURN_LO = 32'sh8000_0000;
  localparam logic signed [ANGLE_W:0]  ANG_HI  = 49'sd140737488355327;
  localparam logic signed [ANGLE_W:0]  ANG_LO  = -49'sd140737488355328;

  logic adv;

  logic        sb_v_r [LAT];
  frame_item_t sb_r   [LAT];

  logic signed [VAL_W-1:0] pos_val, vel_val, tq_val;

  // unwrap stage
  logic signed [CFG_W:0]   range_r;
  logic signed [VAL_W-1:0] prev_pos_r;
  logic signed [CFG_W:0]   diff;
  logic signed [DW-1:0]    diff2, rng, adj;
  logic                    up, dn;
  frame_item_t             sb_last;
  logic                    sb_last_v;

  logic                    u1_v_r;
  frame_item_t             u1_sb_r;
  logic signed [VAL_W-1:0] u1_pos_r, u1_vel_r, u1_tq_r;
  logic signed [DW-1:0]    u1_adj_r;
  logic                    u1_up_r, u1_dn_r;

  // accumulate stage
  logic signed [TURN_W-1:0]  turn_r, turn_nxt;
  logic signed [ANGLE_W-1:0] angle_r, angle_nxt;
  logic signed [ANGLE_W:0]   angle_sum;
  logic                      u1_take;

  logic                      out_valid_r;
  frame_item_t               out_sb_r;
  logic signed [VAL_W-1:0]   out_pos_r, out_vel_r, out_tq_r;
  logic signed [TURN_W-1:0]  out_turn_r;
  logic signed [ANGLE_W-1:0] out_angle_r;

  assign adv = !out_valid_r || out_if.ready;
  assign pop = adv && !q_stat.empty;

  // item side band runs next to the lanes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < LAT; i++) begin
        sb_v_r[i] <= 1'b0;
      end
    end else if (adv) begin
      sb_v_r[0] <= !q_stat.empty;
      for (int i = 1; i < LAT; i++) begin
        sb_v_r[i] <= sb_v_r[i-1];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sb_r[0] <= head;
      for (int i = 1; i < LAT; i++) begin
        sb_r[i] <= sb_r[i-1];
      end
    end
  end

  mfd_map #(.CODE_BITS(POSITION_BITS), .FOLDS(FOLDS)) u_map_pos (
    .clk   (clk),
    .adv   (adv),
    .code  (head.pcode[POSITION_BITS-1:0]),
    .lo    (cfg.pos_min),
    .hi    (cfg.pos_max),
    .value (pos_val)
  );

  mfd_map #(.CODE_BITS(SMALL_FIELD_BITS), .FOLDS(FOLDS)) u_map_vel (
    .clk   (clk),
    .adv   (adv),
    .code  (head.vcode[SMALL_FIELD_BITS-1:0]),
    .lo    (cfg.vel_min),
    .hi    (cfg.vel_max),
    .value (vel_val)
  );

  mfd_map #(.CODE_BITS(SMALL_FIELD_BITS), .FOLDS(FOLDS)) u_map_tq (
    .clk   (clk),
    .adv   (adv),
    .code  (head.tcode[SMALL_FIELD_BITS-1:0]),
    .lo    (cfg.torq_min),
    .hi    (cfg.torq_max),
    .value (tq_val)
  );

  always_ff @(posedge clk) begin
    range_r <= (CFG_W + 1)'(cfg.pos_max) - (CFG_W + 1)'(cfg.pos_min);
  end

  // wrap detection against half the position range
  assign sb_last   = sb_r[LAT-1];
  assign sb_last_v = sb_v_r[LAT-1];

  always_comb begin
    diff  = (CFG_W + 1)'(pos_val) - (CFG_W + 1)'(prev_pos_r);
    diff2 = $signed({diff, 1'b0});
    rng   = DW'(range_r);
    up    = diff2 < -rng;
    dn    = !up && (diff2 > rng);
    if (up) begin
      adj = DW'(diff) + rng;
    end else if (dn) begin
      adj = DW'(diff) - rng;
    end else begin
      adj = DW'(diff);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      u1_v_r     <= 1'b0;
      prev_pos_r <= '0;
    end else if (adv) begin
      u1_v_r <= sb_last_v;
      if (sb_last_v && sb_last.ok) begin
        prev_pos_r <= pos_val;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      u1_sb_r  <= sb_last;
      u1_pos_r <= pos_val;
      u1_vel_r <= vel_val;
      u1_tq_r  <= tq_val;
      u1_adj_r <= adj;
      u1_up_r  <= up;
      u1_dn_r  <= dn;
    end
  end

  // saturating turn count and total angle
  assign u1_take = u1_v_r && u1_sb_r.ok;

  always_comb begin
    turn_nxt  = turn_r;
    angle_nxt = angle_r;
    angle_sum = (ANGLE_W + 1)'(angle_r) + (ANGLE_W + 1)'(u1_adj_r);
    if (u1_take) begin
      if (u1_up_r && turn_r != TURN_HI) begin
        turn_nxt = turn_r + TURN_W'(1);
      end else if (u1_dn_r && turn_r != TURN_LO) begin
        turn_nxt = turn_r - TURN_W'(1);
      end
      if (angle_sum > ANG_HI) begin
        angle_nxt = ANG_HI[ANGLE_W-1:0];
      end else if (angle_sum < ANG_LO) begin
        angle_nxt = ANG_LO[ANGLE_W-1:0];
      end else begin
        angle_nxt = angle_sum[ANGLE_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      turn_r      <= '0;
      angle_r     <= '0;
    end else if (adv) begin
      out_valid_r <= u1_v_r;
      turn_r      <= turn_nxt;
      angle_r     <= angle_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sb_r    <= u1_sb_r;
      out_pos_r   <= u1_pos_r;
      out_vel_r   <= u1_vel_r;
      out_tq_r    <= u1_tq_r;
      out_turn_r  <= turn_nxt;
      out_angle_r <= angle_nxt;
    end
  end

  // rejected frames show zeros except for the multi-turn state
  assign out_if.valid       = out_valid_r;
  assign out_if.accepted    = out_sb_r.ok;
  assign out_if.motor_id    = out_sb_r.ok ? out_sb_r.motor_id : '0;
  assign out_if.fault_code  = out_sb_r.ok ? out_sb_r.fault : '0;
  assign out_if.position    = out_sb_r.ok ? out_pos_r : '0;
  assign out_if.velocity    = out_sb_r.ok ? out_vel_r : '0;
  assign out_if.torque      = out_sb_r.ok ? out_tq_r : '0;
  assign out_if.mos_temp    = out_sb_r.ok ? out_sb_r.mos_temp : '0;
  assign out_if.rotor_temp  = out_sb_r.ok ? out_sb_r.rotor_temp : '0;
  assign out_if.turn_total  = out_turn_r;
  assign out_if.angle_total = out_angle_r;

endmodule

// ===== rtl/motor_feedback_frame_decoder_top.sv =====
// motor_feedback_frame_decoder_top: top level with configuration registers
// depends on mfd_pkg, mfd_if, mfd_front, mfd_fifo, mfd_map and mfd_back
//
// Decodes 8-byte motor feedback frames into id, fault code, position,
// velocity and torque (signed Q16.16, linearly mapped onto the configured
// ranges and rounded to nearest), two raw temperature bytes, and a
// multi-turn view: each accepted position is unwrapped against the last one
// using half the position range, moving a saturating turn count by one and
// adding to a saturating 48-bit total angle. Frames shorter than 8 bytes
// come back with accepted low, zero fields and the unchanged turn count and
// angle. The block takes one word per cycle while in ready is high and
// gives one result word per frame, in order. A frame passes the front
// register, the input queue, the mapping lanes with FOLDS fold steps of
// the divide by 2^bits - 1 (5 at the default field widths), the unwrap
// stage and the result register. Front register and queue keep taking
// words while a result waits at the output; when the queue fills, in ready
// drops. Ranges are to be written through the cfg port while no frame is in
// flight, which the block does not enforce; they apply to the next frame.
module motor_feedback_frame_decoder_top import mfd_pkg::*; #(
  parameter int POSITION_BITS    = POSITION_BITS_DEF,
  parameter int SMALL_FIELD_BITS = SMALL_FIELD_BITS_DEF,
  parameter int QUEUE_DEPTH      = QUEUE_DEPTH_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  mfd_in_if.sink               in_if,
  mfd_out_if.source            out_if
);

  // all three lanes share one depth so the side band stays aligned
  localparam int FOLDS = max_int(fold_steps(POSITION_BITS + CFG_W, POSITION_BITS),
                                 fold_steps(SMALL_FIELD_BITS + CFG_W, SMALL_FIELD_BITS));
  localparam int ITEM_W = $bits(frame_item_t);

  cfg_t        cfg_r;
  q_stat_t     q_stat;
  logic        push, pop;
  frame_item_t front_item, head;
  logic [ITEM_W-1:0] head_bits;

  // range registers, writes beyond the last index are dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.pos_min  <= POS_MIN_RST;
      cfg_r.pos_max  <= POS_MAX_RST;
      cfg_r.vel_min  <= VEL_MIN_RST;
      cfg_r.vel_max  <= VEL_MAX_RST;
      cfg_r.torq_min <= TORQ_MIN_RST;
      cfg_r.torq_max <= TORQ_MAX_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_POS_MIN:  cfg_r.pos_min  <= cfg_wdata;
        REG_POS_MAX:  cfg_r.pos_max  <= cfg_wdata;
        REG_VEL_MIN:  cfg_r.vel_min  <= cfg_wdata;
        REG_VEL_MAX:  cfg_r.vel_max  <= cfg_wdata;
        REG_TORQ_MIN: cfg_r.torq_min <= cfg_wdata;
        REG_TORQ_MAX: cfg_r.torq_max <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // front: length check and field unpack
  mfd_front #(
    .POSITION_BITS    (POSITION_BITS),
    .SMALL_FIELD_BITS (SMALL_FIELD_BITS)
  ) u_front (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_if  (in_if),
    .q_stat (q_stat),
    .push   (push),
    .item   (front_item)
  );

  // queue decouples the front from back-pressure at the output
  mfd_fifo #(
    .WIDTH (ITEM_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (push),
    .din   (front_item),
    .pop   (pop),
    .dout  (head_bits),
    .stat  (q_stat)
  );

  assign head = frame_item_t'(head_bits);

  // back: mapping lanes, unwrap and result register
  mfd_back #(
    .POSITION_BITS    (POSITION_BITS),
    .SMALL_FIELD_BITS (SMALL_FIELD_BITS),
    .FOLDS            (FOLDS)
  ) u_back (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg    (cfg_r),
    .head   (head),
    .q_stat (q_stat),
    .pop    (pop),
    .out_if (out_if)
  );

endmodule
